// ===== rtl/rmstg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmstg_pkg
// Types, codes and constants for the register-mapped square tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rmstg_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned OFF_W    = 3;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned DUR_W    = 14;
	localparam int unsigned AMP_W    = 15;

	localparam logic [FREQ_W-1:0] FREQ_MIN  = 16'd20;
	localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'd20000;
	localparam logic [15:0]       DUR_MIN   = 16'd1;
	localparam logic [15:0]       DUR_MAX   = 16'd10000;
	localparam int unsigned       MS_PER_S  = 1000;
	localparam logic [7:0]        VOL_RESET = 8'd128;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [OFF_W-1:0] {
		OFF_FREQ_LO = 3'd0,
		OFF_FREQ_HI = 3'd1,
		OFF_DUR_LO  = 3'd2,
		OFF_DUR_HI  = 3'd3,
		OFF_VOLUME  = 3'd4,
		OFF_CONTROL = 3'd5
	} reg_off_t;

	// floor(vol * 32767 / 255) = vol*128 + floor(vol*127 / 255)
	function automatic logic [AMP_W-1:0] tone_amp(input logic [7:0] vol);
		logic [AMP_W-1:0] x;
		logic [AMP_W-1:0] q;
		x = {vol, 7'b0} - AMP_W'(vol);
		q = (x + (x >> 8) + AMP_W'(1)) >> 8;
		return {vol, 7'b0} + q;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/register_mapped_square_tone_generator.sv =====
// ----------------------------------------------------------------------------
// register_mapped_square_tone_generator
// Bus-mapped square wave tone source: register reads/writes and sample ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per item: a register
//   read, a register write or one audio sample tick. Output channel
//   (out_valid/out_stall) returns exactly one result beat per input beat, in
//   order: read byte, audio sample and the tone-active flag.
//   A beat is registered in the input stage, then processed in one pass that
//   updates the register file and tone state and loads the output register.
//   One beat per cycle is sustained while the receiver does not stall, set
//   by the single input stage feeding the output register.
//   When the receiver stalls, the output register holds its beat, the input
//   stage fills, and in_stall rises until the output moves again.
//   Reset clears the register file (volume resets to 128), stops any tone and
//   empties both stages; no beats are accepted while arst_n is low.
// ----------------------------------------------------------------------------
`default_nettype none

module register_mapped_square_tone_generator
	import rmstg_pkg::*;
#(
	parameter int unsigned SAMPLE_RATE_HZ = 44100,
	parameter int unsigned PLAY_BIT       = 0,
	parameter int unsigned STATUS_BIT     = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 action,
	input  wire logic [OFF_W-1:0]           reg_offset,
	input  wire logic [DATA_W-1:0]          write_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [DATA_W-1:0]               read_data,
	output logic signed [SAMPLE_W-1:0]      audio_sample,
	output logic                            tone_active
);

	localparam int unsigned REM_W = $clog2(10000 * SAMPLE_RATE_HZ + 1);
	localparam logic [PHASE_W:0] RATE_X = (PHASE_W + 1)'(SAMPLE_RATE_HZ);
	localparam logic [REM_W-1:0] RATE_R = REM_W'(SAMPLE_RATE_HZ);
	localparam logic [REM_W-1:0] STEP_R = REM_W'(MS_PER_S);

	// input stage
	logic                valid_s1;
	action_t             action_s1;
	logic [OFF_W-1:0]    offset_s1;
	logic [DATA_W-1:0]   data_s1;

	// register file and tone state
	logic [DATA_W-1:0]   freq_lo_q, freq_hi_q, dur_lo_q, dur_hi_q, volume_q, control_q;
	logic                playing_q;
	logic [FREQ_W-1:0]   tone_freq_q;
	logic [AMP_W-1:0]    tone_amp_q;
	logic [REM_W-1:0]    remain_q;
	logic [PHASE_W-1:0]  phase_q;

	logic [DATA_W-1:0]   freq_lo_n, freq_hi_n, dur_lo_n, dur_hi_n, volume_n, control_n;
	logic                playing_n;
	logic [FREQ_W-1:0]   tone_freq_n;
	logic [AMP_W-1:0]    tone_amp_n;
	logic [REM_W-1:0]    remain_n;
	logic [PHASE_W-1:0]  phase_n;

	logic                out_valid_q;
	logic [DATA_W-1:0]   rd_q, rd_n;
	logic [SAMPLE_W-1:0] smp_q, smp_n;
	logic                active_q;

	logic                advance;
	logic                fire;
	logic [FREQ_W-1:0]   freq_req;
	logic [15:0]         dur_req;
	logic                req_ok;
	logic [PHASE_W:0]    phase_sum;
	logic [DATA_W-1:0]   status_byte;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign freq_req = {freq_hi_q, freq_lo_q};
	assign dur_req  = {dur_hi_q, dur_lo_q};
	assign req_ok   = (freq_req >= FREQ_MIN) && (freq_req <= FREQ_MAX) &&
		(dur_req >= DUR_MIN) && (dur_req <= DUR_MAX);
	assign phase_sum = {1'b0, phase_q} + {1'b0, tone_freq_q};

	always_comb begin
		status_byte = control_q;
		status_byte[STATUS_BIT] = playing_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action_t'(action);
			offset_s1 <= reg_offset;
			data_s1   <= write_data;
		end
	end

	always_comb begin
		freq_lo_n   = freq_lo_q;
		freq_hi_n   = freq_hi_q;
		dur_lo_n    = dur_lo_q;
		dur_hi_n    = dur_hi_q;
		volume_n    = volume_q;
		control_n   = control_q;
		playing_n   = playing_q;
		tone_freq_n = tone_freq_q;
		tone_amp_n  = tone_amp_q;
		remain_n    = remain_q;
		phase_n     = phase_q;
		rd_n        = '0;
		smp_n       = '0;
		unique case (action_s1)
			ACT_READ: begin
				unique case (offset_s1)
					OFF_FREQ_LO: rd_n = freq_lo_q;
					OFF_FREQ_HI: rd_n = freq_hi_q;
					OFF_DUR_LO:  rd_n = dur_lo_q;
					OFF_DUR_HI:  rd_n = dur_hi_q;
					OFF_VOLUME:  rd_n = volume_q;
					OFF_CONTROL: rd_n = status_byte;
					default:     rd_n = '0;
				endcase
			end
			ACT_WRITE: begin
				unique case (offset_s1)
					OFF_FREQ_LO: freq_lo_n = data_s1;
					OFF_FREQ_HI: freq_hi_n = data_s1;
					OFF_DUR_LO:  dur_lo_n  = data_s1;
					OFF_DUR_HI:  dur_hi_n  = data_s1;
					OFF_VOLUME:  volume_n  = data_s1;
					OFF_CONTROL: begin
						control_n = data_s1;
						if (data_s1[PLAY_BIT]) begin
							if (req_ok) begin
								playing_n   = 1'b1;
								tone_freq_n = freq_req;
								tone_amp_n  = tone_amp(volume_q);
								remain_n    = REM_W'(dur_req[DUR_W-1:0]) * RATE_R;
								phase_n     = '0;
							end
						end else begin
							playing_n = 1'b0;
						end
					end
					default: ;
				endcase
			end
			ACT_TICK: begin
				if (playing_q) begin
					// remain = dur*rate - 1000*samples_done
					if (remain_q < STEP_R) begin
						playing_n = 1'b0;
					end else begin
						remain_n = remain_q - STEP_R;
						if ({phase_q, 1'b0} < RATE_X) begin
							smp_n = {1'b0, tone_amp_q};
						end else begin
							smp_n = SAMPLE_W'(0) - {1'b0, tone_amp_q};
						end
						if (phase_sum >= RATE_X) begin
							phase_n = PHASE_W'(phase_sum - RATE_X);
						end else begin
							phase_n = phase_sum[PHASE_W-1:0];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_lo_q   <= '0;
			freq_hi_q   <= '0;
			dur_lo_q    <= '0;
			dur_hi_q    <= '0;
			volume_q    <= VOL_RESET;
			control_q   <= '0;
			playing_q   <= 1'b0;
			tone_freq_q <= '0;
			tone_amp_q  <= tone_amp(VOL_RESET);
			remain_q    <= '0;
			phase_q     <= '0;
		end else if (fire) begin
			freq_lo_q   <= freq_lo_n;
			freq_hi_q   <= freq_hi_n;
			dur_lo_q    <= dur_lo_n;
			dur_hi_q    <= dur_hi_n;
			volume_q    <= volume_n;
			control_q   <= control_n;
			playing_q   <= playing_n;
			tone_freq_q <= tone_freq_n;
			tone_amp_q  <= tone_amp_n;
			remain_q    <= remain_n;
			phase_q     <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q     <= rd_n;
			smp_q    <= smp_n;
			active_q <= playing_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rd_q;
	assign audio_sample = smp_q;
	assign tone_active  = active_q;

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < RATE_X)
		else $error("phase accumulator out of range");

	a_sample_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action_s1 != ACT_TICK |=> audio_sample == '0)
		else $error("sample on non-tick beat");

	a_read_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action_s1 != ACT_READ |=> read_data == '0)
		else $error("read data on non-read beat");

	a_state_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(playing_q) && $stable(phase_q))
		else $error("tone state moved without a beat");

endmodule

`default_nettype wire
